// ===== rtl/core/rfob_pkg.sv =====
package rfob_pkg;

	// Field widths of an input beat
	localparam int unsigned CoordW = 12;
	localparam int unsigned SpanW  = 11;
	localparam int unsigned ColorW = 16;
	localparam int unsigned WordW  = 16;
	// Signed pixel coordinate: origin plus span needs one extra bit
	localparam int unsigned PosW   = 13;
	localparam int unsigned AddrW  = 16;
	localparam int unsigned RgbW   = 24;

	typedef enum logic [2:0] {
		OP_FILL    = 3'd0,
		OP_OUTLINE = 3'd1,
		OP_BLIT    = 3'd2,
		OP_STEP    = 3'd3,
		OP_DATA    = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_FILL    = 4'b0010,
		MODE_OUTLINE = 4'b0100,
		MODE_BLIT    = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [CoordW-1:0] origin_x;
		logic [CoordW-1:0] origin_y;
		logic [SpanW-1:0]  rect_width;
		logic [SpanW-1:0]  rect_height;
		logic [ColorW-1:0] color565;
		logic [WordW-1:0]  image_hi;
		logic [WordW-1:0]  image_lo;
	} item_t;

	// Pixel request from the walker to the pixel stage
	typedef struct packed {
		logic [PosW-1:0]   x;
		logic [PosW-1:0]   y;
		logic [ColorW-1:0] color;
		logic              fin;
	} pix_req_t;

	typedef struct packed {
		logic             write_enable;
		logic [AddrW-1:0] pixel_addr;
		logic [RgbW-1:0]  color_rgb;
		logic             last;
	} pix_res_t;

	// Widen RGB565 to RGB888, each channel scaled to full range and floored.
	// Multiply by 255 * (2^20 + 30) / 31 (or 255 * (2^20 + 59) / 63) and keep the top byte;
	// the reciprocal error stays below one step over the whole channel range.
	function automatic logic [RgbW-1:0] rgb565_to_888(input logic [ColorW-1:0] c);
		logic [27:0] r;
		logic [27:0] g;
		logic [27:0] b;
		r = {23'd0, c[15:11]} * 28'd8625630;
		g = {22'd0, c[10:5]} * 28'd4244475;
		b = {23'd0, c[4:0]} * 28'd8625630;
		return {r[27:20], g[27:20], b[27:20]};
	endfunction

endpackage

// ===== rtl/core/rect_fill_outline_blit_engine_unit.sv =====
// Rectangle drawing engine for a FRAME_W x FRAME_H frame buffer. A start beat
// (fill, outline or blit) latches origin, size and colour and gives no output;
// each step beat then yields the next fill or outline pixel, and each image data
// beat the next blit pixel. Every pixel beat carries its address x + FRAME_W*y,
// the colour widened to RGB888, a write enable that is low for pixels outside
// the frame (address then zero), and tlast on the final pixel of the command.
// Throughput is one beat per clock while the output is taken: the input register feeds
// the position counters, clip test, colour widening and address multiply into the output
// register, so a pixel beat passes from the input register to the output register;
// a pixel beat that cannot enter a full output register holds the input stage until the
// output is taken.
module rect_fill_outline_blit_engine_unit #(
	parameter int unsigned FRAME_W = 240,
	parameter int unsigned FRAME_H = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// origin_x[11:0], origin_y[23:12], rect_width[34:24], rect_height[45:35],
	// color565[61:46], image_hi[77:62], image_lo[93:78], zero pad [95:94]
	input  logic [95:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_addr[15:0], color_rgb[39:16]
	output logic [39:0] m_tdata,
	// write_enable[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	logic                v_s1;
	rfob_pkg::item_t     item_s1;
	logic                v_s2;
	rfob_pkg::pix_res_t  res_s2;

	logic                has_res;
	logic                out_free;
	logic                adv;
	rfob_pkg::pix_req_t  req;
	rfob_pkg::pix_res_t  res;

	// Move the held beat on when its pixel, if any, has room
	assign out_free = !v_s2 || m_tready;
	assign adv      = v_s1 && (!has_res || out_free);
	assign s_tready = !v_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode      <= s_tuser;
			item_s1.origin_x    <= s_tdata[11:0];
			item_s1.origin_y    <= s_tdata[23:12];
			item_s1.rect_width  <= s_tdata[34:24];
			item_s1.rect_height <= s_tdata[45:35];
			item_s1.color565    <= s_tdata[61:46];
			item_s1.image_hi    <= s_tdata[77:62];
			item_s1.image_lo    <= s_tdata[93:78];
		end
	end

	rfob_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.go      (adv),
		.has_res (has_res),
		.req     (req)
	);

	rfob_pix #(
		.FRAME_W (FRAME_W),
		.FRAME_H (FRAME_H)
	) u_pix (
		.req (req),
		.res (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_free) begin
			v_s2 <= adv && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && has_res) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {res_s2.color_rgb, res_s2.pixel_addr};
	assign m_tuser  = res_s2.write_enable;
	assign m_tlast  = res_s2.last;

	// An empty input stage always takes a beat
	a_empty_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	// A clipped pixel carries a zero address
	a_clip_addr : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[15:0] == 16'd0))
		else $error("clipped pixel with non-zero address");

	// A pixel beat blocked by a full output stage stays in the input stage
	a_hold_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && has_res && v_s2 && !m_tready) |=> v_s1)
		else $error("pending pixel beat lost");

endmodule

// ===== rtl/core/rfob_walk.sv =====
module rfob_walk (
	input  logic             clk,
	input  logic             arst_n,
	input  rfob_pkg::item_t  item,
	input  logic             go,
	output logic             has_res,
	output rfob_pkg::pix_req_t req
);

	rfob_pkg::mode_t                 mode_q, mode_d;
	logic [rfob_pkg::CoordW-1:0]     start_x_q, start_x_d;
	logic [rfob_pkg::CoordW-1:0]     start_y_q, start_y_d;
	logic [rfob_pkg::SpanW-1:0]      span_w_q, span_w_d;
	logic [rfob_pkg::SpanW-1:0]      span_h_q, span_h_d;
	logic [rfob_pkg::ColorW-1:0]     fill_color_q, fill_color_d;
	logic [rfob_pkg::SpanW-1:0]      col_q, col_d;
	logic [rfob_pkg::SpanW-1:0]      row_q, row_d;
	logic                            edge_pass_q, edge_pass_d;
	logic                            edge_side_q, edge_side_d;

	logic [rfob_pkg::PosW-1:0]       x_col, y_row, x_far, y_far;
	logic [rfob_pkg::SpanW:0]        col_inc, row_inc;
	logic                            col_last, row_last, col_end, row_end;

	// Current position: the latched origin plus the column and row counters
	assign x_col = {start_x_q[rfob_pkg::CoordW-1], start_x_q} + {2'b00, col_q};
	assign y_row = {start_y_q[rfob_pkg::CoordW-1], start_y_q} + {2'b00, row_q};
	assign x_far = {start_x_q[rfob_pkg::CoordW-1], start_x_q} + {2'b00, span_w_q}
		- rfob_pkg::PosW'(1);
	assign y_far = {start_y_q[rfob_pkg::CoordW-1], start_y_q} + {2'b00, span_h_q}
		- rfob_pkg::PosW'(1);

	assign col_inc  = {1'b0, col_q} + (rfob_pkg::SpanW+1)'(1);
	assign row_inc  = {1'b0, row_q} + (rfob_pkg::SpanW+1)'(1);
	assign col_last = col_inc == {1'b0, span_w_q};
	assign row_last = row_inc == {1'b0, span_h_q};
	assign col_end  = col_inc >= {1'b0, span_w_q};
	assign row_end  = row_inc >= {1'b0, span_h_q};

	// Decode the beat against the current mode and work out the next state
	always_comb begin
		mode_d       = mode_q;
		start_x_d    = start_x_q;
		start_y_d    = start_y_q;
		span_w_d     = span_w_q;
		span_h_d     = span_h_q;
		fill_color_d = fill_color_q;
		col_d        = col_q;
		row_d        = row_q;
		edge_pass_d  = edge_pass_q;
		edge_side_d  = edge_side_q;
		has_res      = 1'b0;
		req.x        = x_col;
		req.y        = y_row;
		req.color    = fill_color_q;
		req.fin      = 1'b0;
		case (item.opcode)
			rfob_pkg::OP_FILL, rfob_pkg::OP_OUTLINE, rfob_pkg::OP_BLIT: begin
				start_x_d    = item.origin_x;
				start_y_d    = item.origin_y;
				span_w_d     = item.rect_width;
				span_h_d     = item.rect_height;
				fill_color_d = item.color565;
				col_d        = '0;
				row_d        = '0;
				edge_pass_d  = 1'b0;
				edge_side_d  = 1'b0;
				if (item.rect_width == '0 || item.rect_height == '0) begin
					mode_d = rfob_pkg::MODE_IDLE;
				end else if (item.opcode == rfob_pkg::OP_FILL) begin
					mode_d = rfob_pkg::MODE_FILL;
				end else if (item.opcode == rfob_pkg::OP_OUTLINE) begin
					mode_d = rfob_pkg::MODE_OUTLINE;
				end else begin
					mode_d = rfob_pkg::MODE_BLIT;
				end
			end
			rfob_pkg::OP_STEP: begin
				if (mode_q == rfob_pkg::MODE_FILL) begin
					// Fill walks down each column, then moves right
					has_res = 1'b1;
					req.fin = col_last && row_last;
					if (row_end) begin
						row_d = '0;
						col_d = col_inc[rfob_pkg::SpanW-1:0];
					end else begin
						row_d = row_inc[rfob_pkg::SpanW-1:0];
					end
				end else if (mode_q == rfob_pkg::MODE_OUTLINE) begin
					has_res = 1'b1;
					edge_side_d = !edge_side_q;
					if (!edge_pass_q) begin
						// Top and bottom edges, alternating per column
						req.x = x_col;
						req.y = edge_side_q ? y_far : y_row;
						if (edge_side_q) begin
							if (col_end) begin
								col_d       = '0;
								row_d       = '0;
								edge_pass_d = 1'b1;
							end else begin
								col_d = col_inc[rfob_pkg::SpanW-1:0];
							end
						end
					end else begin
						// Left and right edges, alternating per row
						req.x = edge_side_q ? x_far : x_col;
						req.y = y_row;
						if (edge_side_q) begin
							if (row_end) begin
								req.fin = 1'b1;
							end else begin
								row_d = row_inc[rfob_pkg::SpanW-1:0];
							end
						end
					end
				end
			end
			rfob_pkg::OP_DATA: begin
				if (mode_q == rfob_pkg::MODE_BLIT) begin
					// Blit walks row-major, colour from the image words
					has_res   = 1'b1;
					req.color = {item.image_hi[7:0], 8'h00} | item.image_lo;
					req.fin   = col_last && row_last;
					if (col_end) begin
						col_d = '0;
						row_d = row_inc[rfob_pkg::SpanW-1:0];
					end else begin
						col_d = col_inc[rfob_pkg::SpanW-1:0];
					end
				end
			end
			default: begin
			end
		endcase
		if (has_res && req.fin) begin
			mode_d = rfob_pkg::MODE_IDLE;
		end
	end

	// Commit the state when the beat leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= rfob_pkg::MODE_IDLE;
			start_x_q    <= '0;
			start_y_q    <= '0;
			span_w_q     <= '0;
			span_h_q     <= '0;
			fill_color_q <= '0;
			col_q        <= '0;
			row_q        <= '0;
			edge_pass_q  <= 1'b0;
			edge_side_q  <= 1'b0;
		end else if (go) begin
			mode_q       <= mode_d;
			start_x_q    <= start_x_d;
			start_y_q    <= start_y_d;
			span_w_q     <= span_w_d;
			span_h_q     <= span_h_d;
			fill_color_q <= fill_color_d;
			col_q        <= col_d;
			row_q        <= row_d;
			edge_pass_q  <= edge_pass_d;
			edge_side_q  <= edge_side_d;
		end
	end

endmodule

// ===== rtl/core/rfob_pix.sv =====
module rfob_pix #(
	parameter int unsigned FRAME_W = 240,
	parameter int unsigned FRAME_H = 160
) (
	input  rfob_pkg::pix_req_t req,
	output rfob_pkg::pix_res_t res
);

	logic        in_frame;
	logic [21:0] row_base;
	logic [rfob_pkg::AddrW-1:0] addr;

	// Clip against the frame; negative coordinates have the sign bit set
	assign in_frame = !req.x[rfob_pkg::PosW-1] && !req.y[rfob_pkg::PosW-1]
		&& (req.x[rfob_pkg::PosW-2:0] < 12'(FRAME_W))
		&& (req.y[rfob_pkg::PosW-2:0] < 12'(FRAME_H));

	// Linear address x + FRAME_W*y, low bits kept
	assign row_base = {11'd0, 11'(FRAME_W)} * {11'd0, req.y[10:0]};
	assign addr     = row_base[rfob_pkg::AddrW-1:0] + rfob_pkg::AddrW'(req.x[10:0]);

	assign res.write_enable = in_frame;
	assign res.pixel_addr   = in_frame ? addr : '0;
	assign res.color_rgb    = rfob_pkg::rgb565_to_888(req.color);
	assign res.last         = req.fin;

endmodule

// ===== verif/rfob_pixel_checker.sv =====
`timescale 1ns / 1ps

module rfob_pixel_checker #(
	parameter int unsigned FRAME_W = 240,
	parameter int unsigned FRAME_H = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// origin_x[11:0], origin_y[23:12], rect_width[34:24], rect_height[45:35],
	// color565[61:46], image_hi[77:62], image_lo[93:78], zero pad [95:94]
	input  logic [95:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// pixel_addr[15:0], color_rgb[39:16]
	input  logic [39:0] m_tdata,
	// write_enable[0]
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          writes_due
);

	typedef struct {
		bit        write_enable;
		bit [15:0] pixel_addr;
		bit [23:0] color_rgb;
		bit        last;
	} pixel_write_t;

	pixel_write_t writes_expected[$];

	// Mirror of the engine's drawing state
	rfob_pkg::mode_t    mode;
	logic signed [11:0] org_x;
	logic signed [11:0] org_y;
	logic [10:0]        span_w;
	logic [10:0]        span_h;
	logic [15:0]        draw_color;
	logic [10:0]        col_cnt;
	logic [10:0]        row_cnt;
	logic               on_sides;	// 0 while top/bottom edges, 1 while left/right edges
	logic               far_side;	// 0 near edge, 1 far edge

	function automatic bit [23:0] widen_565(input logic [15:0] c);
		int r;
		int g;
		int b;
		r = int'(c[15:11]) * 255 / 31;
		g = int'(c[10:5]) * 255 / 63;
		b = int'(c[4:0]) * 255 / 31;
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	// Queue the write for pixel (x, y); drop back to idle after the final one
	task automatic plot(input int x, input int y, input logic [15:0] c, input bit fin);
		pixel_write_t w;
		w.write_enable = x >= 0 && x < int'(FRAME_W) && y >= 0 && y < int'(FRAME_H);
		w.pixel_addr   = w.write_enable ? 16'(x + int'(FRAME_W) * y) : 16'd0;
		w.color_rgb    = widen_565(c);
		w.last         = fin;
		writes_expected.push_back(w);
		if (fin) begin
			mode = rfob_pkg::MODE_IDLE;
		end
	endtask

	// Advance the drawing state by one accepted beat
	task automatic predict(input logic [2:0] op, input logic [95:0] d);
		int          x;
		int          y;
		bit          fin;
		logic [15:0] c;
		if (op == rfob_pkg::OP_FILL || op == rfob_pkg::OP_OUTLINE
				|| op == rfob_pkg::OP_BLIT) begin
			org_x      = d[11:0];
			org_y      = d[23:12];
			span_w     = d[34:24];
			span_h     = d[45:35];
			draw_color = d[61:46];
			col_cnt    = '0;
			row_cnt    = '0;
			on_sides   = 1'b0;
			far_side   = 1'b0;
			if (span_w == 0 || span_h == 0) begin
				mode = rfob_pkg::MODE_IDLE;
			end else if (op == rfob_pkg::OP_FILL) begin
				mode = rfob_pkg::MODE_FILL;
			end else if (op == rfob_pkg::OP_OUTLINE) begin
				mode = rfob_pkg::MODE_OUTLINE;
			end else begin
				mode = rfob_pkg::MODE_BLIT;
			end
		end else if (op == rfob_pkg::OP_STEP && mode == rfob_pkg::MODE_FILL) begin
			// column by column, top to bottom within a column
			x   = int'(org_x) + int'(col_cnt);
			y   = int'(org_y) + int'(row_cnt);
			fin = int'(col_cnt) + 1 == int'(span_w) && int'(row_cnt) + 1 == int'(span_h);
			if (int'(row_cnt) + 1 >= int'(span_h)) begin
				row_cnt = '0;
				col_cnt = col_cnt + 11'd1;
			end else begin
				row_cnt = row_cnt + 11'd1;
			end
			plot(x, y, draw_color, fin);
		end else if (op == rfob_pkg::OP_STEP && mode == rfob_pkg::MODE_OUTLINE) begin
			fin = 1'b0;
			if (!on_sides) begin
				// top then bottom for each column
				x = int'(org_x) + int'(col_cnt);
				y = far_side ? int'(org_y) + int'(span_h) - 1 : int'(org_y);
				if (far_side) begin
					far_side = 1'b0;
					if (int'(col_cnt) + 1 >= int'(span_w)) begin
						col_cnt  = '0;
						row_cnt  = '0;
						on_sides = 1'b1;
					end else begin
						col_cnt = col_cnt + 11'd1;
					end
				end else begin
					far_side = 1'b1;
				end
			end else begin
				// left then right for each row
				x = far_side ? int'(org_x) + int'(span_w) - 1 : int'(org_x);
				y = int'(org_y) + int'(row_cnt);
				if (far_side) begin
					far_side = 1'b0;
					if (int'(row_cnt) + 1 >= int'(span_h)) begin
						fin = 1'b1;
					end else begin
						row_cnt = row_cnt + 11'd1;
					end
				end else begin
					far_side = 1'b1;
				end
			end
			plot(x, y, draw_color, fin);
		end else if (op == rfob_pkg::OP_DATA && mode == rfob_pkg::MODE_BLIT) begin
			// row-major; low byte of the first word forms the high colour byte
			c   = {d[69:62], 8'h00} | d[93:78];
			x   = int'(org_x) + int'(col_cnt);
			y   = int'(org_y) + int'(row_cnt);
			fin = int'(col_cnt) + 1 == int'(span_w) && int'(row_cnt) + 1 == int'(span_h);
			if (int'(col_cnt) + 1 >= int'(span_w)) begin
				col_cnt = '0;
				row_cnt = row_cnt + 11'd1;
			end else begin
				col_cnt = col_cnt + 11'd1;
			end
			plot(x, y, c, fin);
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each pixel beat with the oldest write due, then predict from the input beat
	always @(posedge clk or negedge arst_n) begin
		pixel_write_t due;
		if (!arst_n) begin
			mode       = rfob_pkg::MODE_IDLE;
			org_x      = '0;
			org_y      = '0;
			span_w     = '0;
			span_h     = '0;
			draw_color = '0;
			col_cnt    = '0;
			row_cnt    = '0;
			on_sides   = 1'b0;
			far_side   = 1'b0;
			writes_expected.delete();
			writes_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (writes_expected.size() == 0) begin
					$error("pixel beat with no write due: pixel_addr %0h", m_tdata[15:0]);
					mismatches++;
				end else begin
					due = writes_expected.pop_front();
					check_field("write_enable", due.write_enable, m_tuser);
					check_field("pixel_addr", due.pixel_addr, m_tdata[15:0]);
					check_field("color_rgb", due.color_rgb, m_tdata[39:16]);
					check_field("last", due.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready) begin
				predict(s_tuser, s_tdata);
			end
			writes_due = writes_expected.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned FrameW = 240;
	localparam int unsigned FrameH = 160;
	localparam int ItemsPerPhase = 280;
	localparam int HoldCycles = 300;
	localparam int Limit = 200000;
	// Opcodes the engine has no use for
	localparam logic [2:0] OpSpareLo = 3'd5;
	localparam logic [2:0] OpSpareHi = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int mismatches;
	int writes_due;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int beats_counted = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #6 clk = ~clk;

	rect_fill_outline_blit_engine_unit #(
		.FRAME_W(FrameW),
		.FRAME_H(FrameH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	rfob_pixel_checker #(
		.FRAME_W(FrameW),
		.FRAME_H(FrameH)
	) pixel_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches),
		.writes_due(writes_due)
	);

	// Abandon a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == Limit) begin
			$display("rect_fill_outline_blit_engine_unit verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always begin
		@(posedge clk);
		if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			repeat (HoldCycles) @(posedge clk);
			hold_done = 1'b1;
		end
		m_tready <= $urandom_range(99, 0) >= stall_pct;
	end

	// Offer one beat after random idle cycles and hold it until taken
	task automatic drive_beat(input logic [2:0] op, input logic [11:0] ox, input logic [11:0] oy,
			input logic [10:0] w, input logic [10:0] h, input logic [15:0] col,
			input logic [15:0] hi, input logic [15:0] lo);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, lo, hi, col, h, w, oy, ox};
		do @(posedge clk); while (!s_tready);
		beats_counted++;
	endtask

	// Beat whose operands are noise
	task automatic drive_filler(input logic [2:0] op);
		drive_beat(op, 12'($urandom), 12'($urandom), 11'($urandom), 11'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Start a rectangle and feed its pixels with stray beats mixed in; sometimes cut short
	task automatic draw_rect();
		logic [2:0] op;
		int         w;
		int         h;
		int         ox;
		int         oy;
		int         pixels;
		int         cut;
		int         pick;
		case ($urandom_range(2, 0))
			0: op = rfob_pkg::OP_FILL;
			1: op = rfob_pkg::OP_OUTLINE;
			default: op = rfob_pkg::OP_BLIT;
		endcase
		pick = $urandom_range(99, 0);
		if (pick < 2) begin
			w = 0;
			h = $urandom_range(2047, 0);
		end else if (pick < 4) begin
			w = $urandom_range(2047, 0);
			h = 0;
		end else if (pick < 8) begin
			w = $urandom_range(2047, 0);
			h = $urandom_range(2047, 0);
		end else if (pick < 14) begin
			w = $urandom_range(1, 0) ? $urandom_range(30, 1) : 1;
			h = w == 1 ? $urandom_range(30, 1) : 1;
		end else begin
			w = $urandom_range(6, 1);
			h = $urandom_range(6, 1);
		end
		if ($urandom_range(3, 0) == 0) begin
			ox = $urandom_range(4095, 0);
			oy = $urandom_range(4095, 0);
		end else begin
			ox = int'($urandom_range(FrameW + 8, 0)) - 6 - w / 2;
			oy = int'($urandom_range(FrameH + 8, 0)) - 6 - h / 2;
		end
		if (w == 0 || h == 0) begin
			pixels = 0;
		end else if (op == rfob_pkg::OP_OUTLINE) begin
			pixels = 2 * w + 2 * h;
		end else begin
			pixels = w * h;
		end
		cut = pixels;
		if (pixels > 60 || $urandom_range(9, 0) == 0) begin
			cut = $urandom_range(pixels > 60 ? 60 : pixels, 0);
		end
		drive_beat(op, 12'(ox), 12'(oy), 11'(w), 11'(h), 16'($urandom), 16'($urandom),
			16'($urandom));
		if (pixels == 0) begin
			drive_filler(op == rfob_pkg::OP_BLIT ? rfob_pkg::OP_DATA : rfob_pkg::OP_STEP);
		end
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(9, 0) == 0) begin
				if ($urandom_range(1, 0) == 0) begin
					drive_filler(3'($urandom_range(OpSpareHi, OpSpareLo)));
				end else begin
					drive_filler(op == rfob_pkg::OP_BLIT ? rfob_pkg::OP_STEP
						: rfob_pkg::OP_DATA);
				end
			end
			drive_filler(op == rfob_pkg::OP_BLIT ? rfob_pkg::OP_DATA : rfob_pkg::OP_STEP);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stray beats while idle
		drive_filler(rfob_pkg::OP_STEP);
		drive_filler(rfob_pkg::OP_DATA);
		drive_filler(OpSpareLo);
		drive_filler(OpSpareHi);
		// Fill straddling the top-left corner, full white
		drive_beat(rfob_pkg::OP_FILL, 12'hFFF, 12'hFFF, 11'd2, 11'd2, 16'hFFFF, 16'h0000,
			16'h0000);
		repeat (4) drive_filler(rfob_pkg::OP_STEP);
		// One-wide outline on the bottom-right corner, left and right writes coincide
		drive_beat(rfob_pkg::OP_OUTLINE, 12'd239, 12'd159, 11'd1, 11'd2, 16'hF800, 16'h0000,
			16'h0000);
		repeat (6) drive_filler(rfob_pkg::OP_STEP);
		// Single-pixel blit at the coordinate extremes
		drive_beat(rfob_pkg::OP_BLIT, 12'h800, 12'h7FF, 11'd1, 11'd1, 16'h0000, 16'h0000,
			16'h0000);
		drive_beat(rfob_pkg::OP_DATA, 12'h000, 12'h000, 11'd0, 11'd0, 16'h0000, 16'hFFFF,
			16'hFFFF);
		// Empty rectangle stays idle
		drive_beat(rfob_pkg::OP_FILL, 12'd0, 12'd0, 11'd0, 11'd5, 16'h07E0, 16'h0000,
			16'h0000);
		drive_filler(rfob_pkg::OP_STEP);
		// Largest rectangle, abandoned by the next start
		drive_beat(rfob_pkg::OP_FILL, 12'h7FF, 12'h800, 11'h7FF, 11'h7FF, 16'h001F, 16'h0000,
			16'h0000);
		drive_filler(rfob_pkg::OP_STEP);
		// Blit with a mismatched step in the middle
		drive_beat(rfob_pkg::OP_BLIT, 12'd0, 12'd0, 11'd2, 11'd1, 16'h0000, 16'h0000,
			16'h0000);
		drive_beat(rfob_pkg::OP_DATA, 12'h000, 12'h000, 11'd0, 11'd0, 16'h0000, 16'h0000,
			16'h0000);
		drive_filler(rfob_pkg::OP_STEP);
		drive_beat(rfob_pkg::OP_DATA, 12'h000, 12'h000, 11'd0, 11'd0, 16'h0000, 16'h00A5,
			16'h5A00);

		// Random rectangles under each idling pattern
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_req  = 1'b1;
				end
				1: begin
					idle_pct  = 48;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 48;
				end
				default: begin
					idle_pct  = 8;
					stall_pct = 8;
				end
			endcase
			beats_counted = 0;
			while (beats_counted < ItemsPerPhase) begin
				draw_rect();
			end
		end
		s_tvalid <= 1'b0;

		// Let the checker see the last beat, drain the writes due, then allow for the pipeline
		@(posedge clk);
		while (writes_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("rect_fill_outline_blit_engine_unit verification clean");
		end else begin
			$display("rect_fill_outline_blit_engine_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rfob_pkg.sv
rtl/core/rfob_walk.sv
rtl/core/rfob_pix.sv
rtl/core/rect_fill_outline_blit_engine_unit.sv
verif/rfob_pixel_checker.sv
verif/testbench.sv
